[src/scm_pkg.sv]
// Shared types and constants for the search convergence monitor.
// Command codes, register map, reset values and field widths; no dependencies.
package scm_pkg;

   typedef enum logic [1:0] {
      CMD_OBSERVE    = 2'd0,
      CMD_RESTART    = 2'd1,
      CMD_TIME_CHECK = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_SCORE_EPS   = 3'd0,
      REG_UTIL_EPS    = 3'd1,
      REG_LOW_MOVES   = 3'd2,
      REG_PASS_CAP    = 3'd3,
      REG_STALL_PASS  = 3'd4,
      REG_STALL_TIME  = 3'd5,
      REG_REQUIRE_ALL = 3'd6
   } reg_index_type;

   localparam int CSR_ADDR_W  = 5;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 40;

   localparam logic [31:0] RST_SCORE_EPS  = 32'd85899;
   localparam logic [24:0] RST_UTIL_EPS   = 25'd1678;
   localparam logic [15:0] RST_LOW_MOVES  = 16'd1;
   localparam logic [15:0] RST_PASS_CAP   = 16'd14;
   localparam logic [15:0] RST_STALL_PASS = 16'd8;
   localparam logic [19:0] RST_STALL_TIME = 20'd5000;

   localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

[src/search_convergence_monitor.sv]
// Search convergence monitor: input register, single-pass update, result register.
// Depends on scm_pkg for command codes, register map and reset values.
//
// Usage: each transfer on the req_ stream carries one command (req_tuser) and a
// per-pass observation (req_tdata). Each command yields exactly one result on the
// rsp_ stream: stop decision, improvement flag and both saturating pass counters.
// The csr_ APB port holds the seven thresholds; write it only while the block is
// idle. pready is always high, so a write completes in its access cycle.
// A request is held in the input register and its result in the result register;
// rsp_tvalid rises once the result register is loaded. Throughput: one item per
// cycle while the receiver does not stall; the state loop through the score
// threshold multiply and the compares sets that rate.
// When the receiver stalls, the result register holds and the input register
// fills; req_tready drops only once both are occupied, and rises again as soon
// as the result is taken.
// Reset clears both stages, the monitor state and loads the default thresholds.
// No clearing pass is needed; the first transfer is accepted right after reset.
module search_convergence_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // score[31:0], utilization[56:32], layout_valid[57], accepted_moves[89:58],
   // now_ms[121:90], zero fill[127:122]
   input  logic [scm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // stop[0], improved[1], stagnant_count[17:2], pass_count[33:18], zero fill[39:34]
   output logic [scm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import scm_pkg::*;

   logic [31:0] score_eps_ff;
   logic [24:0] util_eps_ff;
   logic [15:0] low_moves_ff;
   logic [15:0] pass_cap_ff;
   logic [15:0] stall_pass_ff;
   logic [19:0] stall_time_ff;
   logic        require_all_ff;

   logic        csr_write;
   logic [2:0]  csr_index;

   logic        s1_valid_ff;
   logic [1:0]  s1_cmd_ff;
   logic [31:0] s1_score_ff;
   logic [24:0] s1_util_ff;
   logic        s1_lvalid_ff;
   logic [31:0] s1_moves_ff;
   logic [31:0] s1_now_ff;

   logic        rsp_valid_ff;
   logic        rsp_stop_ff, rsp_stop_in;
   logic        rsp_impr_ff, rsp_impr_in;
   logic [15:0] rsp_stag_ff;
   logic [15:0] rsp_pass_ff;

   logic        started_ff, started_in;
   logic [31:0] best_score_ff, best_score_in;
   logic [24:0] best_util_ff, best_util_in;
   logic [31:0] last_moves_ff, last_moves_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] stag_ff, stag_in;

   logic        advance;
   logic [31:0] best_mag;
   logic [31:0] scale;
   logic [63:0] product;
   logic [31:0] thr;
   logic        s_imp, u_imp;
   logic [31:0] delta;
   logic [31:0] elapsed;
   logic        by_pass, by_time, capped;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         score_eps_ff   <= RST_SCORE_EPS;
         util_eps_ff    <= RST_UTIL_EPS;
         low_moves_ff   <= RST_LOW_MOVES;
         pass_cap_ff    <= RST_PASS_CAP;
         stall_pass_ff  <= RST_STALL_PASS;
         stall_time_ff  <= RST_STALL_TIME;
         require_all_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_SCORE_EPS:   score_eps_ff   <= csr_pwdata;
            REG_UTIL_EPS:    util_eps_ff    <= csr_pwdata[24:0];
            REG_LOW_MOVES:   low_moves_ff   <= csr_pwdata[15:0];
            REG_PASS_CAP:    pass_cap_ff    <= csr_pwdata[15:0];
            REG_STALL_PASS:  stall_pass_ff  <= csr_pwdata[15:0];
            REG_STALL_TIME:  stall_time_ff  <= csr_pwdata[19:0];
            REG_REQUIRE_ALL: require_all_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SCORE_EPS:   csr_prdata = score_eps_ff;
         REG_UTIL_EPS:    csr_prdata = {7'd0, util_eps_ff};
         REG_LOW_MOVES:   csr_prdata = {16'd0, low_moves_ff};
         REG_PASS_CAP:    csr_prdata = {16'd0, pass_cap_ff};
         REG_STALL_PASS:  csr_prdata = {16'd0, stall_pass_ff};
         REG_STALL_TIME:  csr_prdata = {12'd0, stall_time_ff};
         REG_REQUIRE_ALL: csr_prdata = {31'd0, require_all_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // handshake: advance moves the input register into the result register
   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_pass_ff, rsp_stag_ff, rsp_impr_ff, rsp_stop_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         s1_cmd_ff    <= req_tuser;
         s1_score_ff  <= req_tdata[31:0];
         s1_util_ff   <= req_tdata[56:32];
         s1_lvalid_ff <= req_tdata[57];
         s1_moves_ff  <= req_tdata[89:58];
         s1_now_ff    <= req_tdata[121:90];
      end
      if (advance) begin
         rsp_stop_ff <= rsp_stop_in;
         rsp_impr_ff <= rsp_impr_in;
         rsp_stag_ff <= stag_in;
         rsp_pass_ff <= total_in;
      end
   end

   // improvement tests against the current best
   assign best_mag = best_score_ff[31] ? (32'd0 - best_score_ff) : best_score_ff;
   assign scale    = (best_mag < SCALE_ONE) ? SCALE_ONE : best_mag;
   assign product  = {32'd0, score_eps_ff} * {32'd0, scale};
   assign thr      = product[63:32];
   assign s_imp    = s1_lvalid_ff &
                     ($signed({{2{s1_score_ff[31]}}, s1_score_ff}) + $signed({2'b00, thr})
                      < $signed({{2{best_score_ff[31]}}, best_score_ff}));
   assign u_imp    = s1_lvalid_ff &
                     ({1'b0, s1_util_ff} > ({1'b0, best_util_ff} + {1'b0, util_eps_ff}));
   assign delta    = (s1_moves_ff >= last_moves_ff) ? (s1_moves_ff - last_moves_ff) : 32'd0;

   always_comb begin
      started_in    = started_ff;
      best_score_in = best_score_ff;
      best_util_in  = best_util_ff;
      last_moves_in = last_moves_ff;
      last_time_in  = last_time_ff;
      total_in      = total_ff;
      stag_in       = stag_ff;
      rsp_impr_in   = 1'b0;
      if (s1_cmd_ff == CMD_RESTART || (s1_cmd_ff == CMD_OBSERVE && !started_ff)) begin
         started_in    = 1'b1;
         best_score_in = s1_score_ff;
         best_util_in  = s1_util_ff;
         last_moves_in = s1_moves_ff;
         last_time_in  = s1_now_ff;
         total_in      = 16'd0;
         stag_in       = 16'd0;
      end else if (s1_cmd_ff == CMD_OBSERVE) begin
         if (total_ff != COUNT_MAX) begin
            total_in = total_ff + 16'd1;
         end
         last_moves_in = s1_moves_ff;
         if (s_imp | u_imp) begin
            best_score_in = s1_score_ff;
            best_util_in  = s1_util_ff;
            last_time_in  = s1_now_ff;
            stag_in       = 16'd0;
            rsp_impr_in   = 1'b1;
         end else if (delta <= {16'd0, low_moves_ff}) begin
            if (stag_ff != COUNT_MAX) begin
               stag_in = stag_ff + 16'd1;
            end
         end
      end
   end

   // stop decision on the updated state
   assign elapsed = s1_now_ff - last_time_in;
   assign by_pass = stag_in >= stall_pass_ff;
   assign by_time = elapsed >= {12'd0, stall_time_ff};
   assign capped  = (pass_cap_ff != 16'd0) & (total_in >= pass_cap_ff);
   assign rsp_stop_in = started_in &
                        (capped | (require_all_ff ? (by_pass & by_time) : (by_pass | by_time)));

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         best_score_ff <= 32'd0;
         best_util_ff  <= 25'd0;
         last_moves_ff <= 32'd0;
         last_time_ff  <= 32'd0;
         total_ff      <= 16'd0;
         stag_ff       <= 16'd0;
      end else if (advance) begin
         started_ff    <= started_in;
         best_score_ff <= best_score_in;
         best_util_ff  <= best_util_in;
         last_moves_ff <= last_moves_in;
         last_time_ff  <= last_time_in;
         total_ff      <= total_in;
         stag_ff       <= stag_in;
      end
   end

   a_stag_le_total: assert property (@(posedge clock) disable iff (reset)
      stag_ff <= total_ff)
      else $error("stagnant count exceeds pass count");

   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (total_ff == 16'd0 && stag_ff == 16'd0))
      else $error("counters nonzero before start");

   a_improved_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_impr_ff) |-> (rsp_stag_ff == 16'd0 && started_ff))
      else $error("improvement without cleared stagnant count");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_cmd_ff == CMD_RESTART) |=> (total_ff == 16'd0 && stag_ff == 16'd0))
      else $error("restart did not clear counters");

endmodule
